[rtl/xibe_pkg.sv]
// Package for the x86 instruction byte encoder.
// Holds the command codes, the opcode tables and the encoded-instruction type.
// Has no dependencies; the encoder, serializer, top level and verification files import it.
package xibe_pkg;

    localparam int MaxBytes = 7;

    // Command codes.
    localparam logic [5:0] CMD_PUSH_R     = 6'd0;
    localparam logic [5:0] CMD_PUSH_I8    = 6'd1;
    localparam logic [5:0] CMD_PUSH_I32   = 6'd2;
    localparam logic [5:0] CMD_PUSH_M     = 6'd3;
    localparam logic [5:0] CMD_POP_R      = 6'd4;
    localparam logic [5:0] CMD_MOV_RR     = 6'd5;
    localparam logic [5:0] CMD_LOAD_BD    = 6'd6;
    localparam logic [5:0] CMD_STORE_BD   = 6'd7;
    localparam logic [5:0] CMD_LOAD_FR    = 6'd8;
    localparam logic [5:0] CMD_STORE_FR   = 6'd9;
    localparam logic [5:0] CMD_LOAD_ABS   = 6'd10;
    localparam logic [5:0] CMD_STORE_ABS  = 6'd11;
    localparam logic [5:0] CMD_MOV_RI     = 6'd12;
    localparam logic [5:0] CMD_STORE_BDI  = 6'd13;
    localparam logic [5:0] CMD_ALU_FIRST  = 6'd14;
    localparam logic [5:0] CMD_ALU_LAST   = 6'd23;
    localparam logic [5:0] CMD_INC        = 6'd24;
    localparam logic [5:0] CMD_DEC        = 6'd25;
    localparam logic [5:0] CMD_TEST_RR    = 6'd26;
    localparam logic [5:0] CMD_CMP_RR     = 6'd27;
    localparam logic [5:0] CMD_CMP_RI     = 6'd28;
    localparam logic [5:0] CMD_CALL_M     = 6'd29;
    localparam logic [5:0] CMD_CALL_REL   = 6'd30;
    localparam logic [5:0] CMD_JMP        = 6'd31;
    localparam logic [5:0] CMD_JCC_FIRST  = 6'd32;
    localparam logic [5:0] CMD_JCC_LAST   = 6'd41;
    localparam logic [5:0] CMD_SETCC_FIRST = 6'd42;
    localparam logic [5:0] CMD_SETCC_LAST  = 6'd51;
    localparam logic [5:0] CMD_MOVZX      = 6'd52;
    localparam logic [5:0] CMD_RET        = 6'd53;
    localparam logic [5:0] CMD_RET_IMM    = 6'd54;
    localparam logic [5:0] CMD_LEAVE      = 6'd55;

    // Fixed opcodes.
    localparam logic [7:0] OP_MOV_STORE = 8'h89;
    localparam logic [7:0] OP_MOV_LOAD  = 8'h8B;
    localparam logic [7:0] OP_MOV_MI    = 8'hC7;
    localparam logic [7:0] OP_GRP1_I8   = 8'h80;
    localparam logic [7:0] OP_GRP1_I32  = 8'h81;
    localparam logic [7:0] OP_GRP1_S8   = 8'h83;
    localparam logic [7:0] OP_TWO_BYTE  = 8'h0F;
    localparam logic [7:0] OP_GRP5      = 8'hFF;
    localparam logic [7:0] OP_PUSH_R    = 8'h50;
    localparam logic [7:0] OP_POP_R     = 8'h58;
    localparam logic [7:0] OP_MOV_RI    = 8'hB8;
    localparam logic [7:0] OP_JMP_REL32 = 8'hE9;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [MaxBytes-1:0][7:0] bytes;
        logic [2:0]               len;
    } enc_t;

    function automatic byte_t mrm(input logic [1:0] md, input logic [2:0] rg,
                                  input logic [2:0] rm);
        return {md, rg, rm};
    endfunction

    function automatic logic [2:0] alu_ext(input logic [2:0] a);
        case (a)
            3'd0: return 3'd0;
            3'd1: return 3'd5;
            3'd2: return 3'd1;
            3'd3: return 3'd4;
            3'd4: return 3'd6;
            default: return 3'd0;
        endcase
    endfunction

    function automatic byte_t alu_rr(input logic [2:0] a);
        case (a)
            3'd0: return 8'h01;
            3'd1: return 8'h29;
            3'd2: return 8'h09;
            3'd3: return 8'h21;
            3'd4: return 8'h31;
            default: return 8'h00;
        endcase
    endfunction

    function automatic byte_t alu_al8(input logic [2:0] a);
        case (a)
            3'd0: return 8'h04;
            3'd1: return 8'h2C;
            3'd2: return 8'h0C;
            3'd3: return 8'h24;
            3'd4: return 8'h34;
            default: return 8'h00;
        endcase
    endfunction

    function automatic byte_t alu_eax(input logic [2:0] a);
        case (a)
            3'd0: return 8'h05;
            3'd1: return 8'h2D;
            3'd2: return 8'h0D;
            3'd3: return 8'h25;
            3'd4: return 8'h35;
            default: return 8'h00;
        endcase
    endfunction

    function automatic byte_t cond_code(input logic [3:0] c);
        case (c)
            4'd0: return 8'h74;
            4'd1: return 8'h75;
            4'd2: return 8'h7C;
            4'd3: return 8'h7E;
            4'd4: return 8'h7F;
            4'd5: return 8'h7D;
            4'd6: return 8'h77;
            4'd7: return 8'h73;
            4'd8: return 8'h72;
            4'd9: return 8'h76;
            default: return 8'h00;
        endcase
    endfunction

endpackage

[rtl/xibe_in_if.sv]
// Request channel of the instruction byte encoder: valid/ready plus request fields.
// Depends on nothing.
interface xibe_in_if;
    logic               valid;
    logic               ready;
    logic [5:0]         command;
    logic [2:0]         reg_a;
    logic [2:0]         reg_b;
    logic signed [31:0] signed_value;
    logic [31:0]        unsigned_value;

    modport source (output valid, command, reg_a, reg_b, signed_value, unsigned_value,
                    input ready);
    modport sink (input valid, command, reg_a, reg_b, signed_value, unsigned_value,
                  output ready);
endinterface

[rtl/xibe_out_if.sv]
// Byte channel of the instruction byte encoder: valid/ready, code byte and last flag.
// Depends on nothing.
interface xibe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       last;

    modport source (output valid, code_byte, last, input ready);
    modport sink (input valid, code_byte, last, output ready);
endinterface

[rtl/xibe_encoder.sv]
// Combinational encoder: maps one registered request to up to seven code bytes.
// Depends on xibe_pkg.
module xibe_encoder
    import xibe_pkg::*;
(
    input  logic [5:0]  command,
    input  logic [2:0]  reg_a,
    input  logic [2:0]  reg_b,
    input  logic [31:0] signed_value,
    input  logic [31:0] unsigned_value,
    output enc_t        enc
);

    logic       fits_s8;
    logic       fits_u8;
    logic [5:0] alu_off;
    logic [2:0] alu_sel;
    logic [5:0] jcc_off;
    logic [5:0] set_off;
    byte_t      cc_j;
    byte_t      cc_s;
    byte_t      sv8;
    logic [2:0] ext;

    assign fits_s8 = (signed_value[31:7] == '0) || (signed_value[31:7] == '1);
    assign fits_u8 = (signed_value[31:8] == '0);
    assign alu_off = command - CMD_ALU_FIRST;
    assign alu_sel = alu_off[3:1];
    assign jcc_off = command - CMD_JCC_FIRST;
    assign set_off = command - CMD_SETCC_FIRST;
    assign cc_j    = cond_code(jcc_off[3:0]);
    assign cc_s    = cond_code(set_off[3:0]);
    assign sv8     = signed_value[7:0];
    assign ext     = alu_ext(alu_sel);

    always_comb
    begin
        enc.bytes = '0;
        enc.len   = 3'd0;
        case (command) inside
            [CMD_ALU_FIRST:CMD_ALU_LAST]:
            begin
                if (!alu_off[0])
                begin
                    enc.bytes[0] = alu_rr(alu_sel);
                    enc.bytes[1] = mrm(2'd3, reg_b, reg_a);
                    enc.len      = 3'd2;
                end
                else if (reg_a == 3'd0)
                begin
                    if (fits_u8)
                    begin
                        enc.bytes[0] = alu_al8(alu_sel);
                        enc.bytes[1] = sv8;
                        enc.len      = 3'd2;
                    end
                    else
                    begin
                        enc.bytes[0]   = alu_eax(alu_sel);
                        enc.bytes[4:1] = signed_value;
                        enc.len        = 3'd5;
                    end
                end
                else if (fits_u8)
                begin
                    enc.bytes[0] = OP_GRP1_I8;
                    enc.bytes[1] = mrm(2'd3, ext, reg_a);
                    enc.bytes[2] = sv8;
                    enc.len      = 3'd3;
                end
                else
                begin
                    enc.bytes[0]   = OP_GRP1_I32;
                    enc.bytes[1]   = mrm(2'd3, ext, reg_a);
                    enc.bytes[5:2] = signed_value;
                    enc.len        = 3'd6;
                end
            end
            [CMD_JCC_FIRST:CMD_JCC_LAST]:
            begin
                if (fits_s8)
                begin
                    enc.bytes[0] = cc_j;
                    enc.bytes[1] = sv8;
                    enc.len      = 3'd2;
                end
                else
                begin
                    enc.bytes[0]   = OP_TWO_BYTE;
                    enc.bytes[1]   = cc_j + 8'h10;
                    enc.bytes[5:2] = signed_value;
                    enc.len        = 3'd6;
                end
            end
            [CMD_SETCC_FIRST:CMD_SETCC_LAST]:
            begin
                enc.bytes[0] = OP_TWO_BYTE;
                enc.bytes[1] = cc_s + 8'h20;
                enc.bytes[2] = mrm(2'd3, reg_a, reg_a);
                enc.len      = 3'd3;
            end
            CMD_PUSH_R:
            begin
                enc.bytes[0] = OP_PUSH_R | {5'd0, reg_a};
                enc.len      = 3'd1;
            end
            CMD_PUSH_I8:
            begin
                enc.bytes[0] = 8'h6A;
                enc.bytes[1] = unsigned_value[7:0];
                enc.len      = 3'd2;
            end
            CMD_PUSH_I32:
            begin
                enc.bytes[0]   = 8'h68;
                enc.bytes[4:1] = unsigned_value;
                enc.len        = 3'd5;
            end
            CMD_PUSH_M, CMD_CALL_M:
            begin
                enc.bytes[0]   = OP_GRP5;
                enc.bytes[1]   = (command == CMD_PUSH_M) ? 8'h35 : 8'h15;
                enc.bytes[5:2] = unsigned_value;
                enc.len        = 3'd6;
            end
            CMD_POP_R:
            begin
                enc.bytes[0] = OP_POP_R | {5'd0, reg_a};
                enc.len      = 3'd1;
            end
            CMD_MOV_RR, CMD_TEST_RR, CMD_CMP_RR:
            begin
                case (command)
                    CMD_MOV_RR:  enc.bytes[0] = OP_MOV_STORE;
                    CMD_TEST_RR: enc.bytes[0] = 8'h85;
                    default:     enc.bytes[0] = 8'h39;
                endcase
                enc.bytes[1] = mrm(2'd3, reg_b, reg_a);
                enc.len      = 3'd2;
            end
            CMD_LOAD_BD, CMD_STORE_BD, CMD_LOAD_FR, CMD_STORE_FR:
            begin
                logic       short_ok;
                logic [2:0] base;
                short_ok = (command == CMD_LOAD_BD || command == CMD_STORE_BD)
                         ? fits_s8 : fits_u8;
                base     = (command == CMD_LOAD_BD || command == CMD_STORE_BD)
                         ? reg_b : 3'd5;
                enc.bytes[0] = (command == CMD_LOAD_BD || command == CMD_LOAD_FR)
                             ? OP_MOV_LOAD : OP_MOV_STORE;
                if (short_ok)
                begin
                    enc.bytes[1] = mrm(2'd1, reg_a, base);
                    enc.bytes[2] = sv8;
                    enc.len      = 3'd3;
                end
                else
                begin
                    enc.bytes[1]   = mrm(2'd2, reg_a, base);
                    enc.bytes[5:2] = signed_value;
                    enc.len        = 3'd6;
                end
            end
            CMD_LOAD_ABS, CMD_STORE_ABS:
            begin
                if (reg_a == 3'd0)
                begin
                    enc.bytes[0]   = (command == CMD_LOAD_ABS) ? 8'hA1 : 8'hA3;
                    enc.bytes[4:1] = unsigned_value;
                    enc.len        = 3'd5;
                end
                else
                begin
                    enc.bytes[0]   = (command == CMD_LOAD_ABS) ? OP_MOV_LOAD : OP_MOV_STORE;
                    enc.bytes[1]   = mrm(2'd0, reg_a, 3'd5);
                    enc.bytes[5:2] = unsigned_value;
                    enc.len        = 3'd6;
                end
            end
            CMD_MOV_RI:
            begin
                enc.bytes[0]   = OP_MOV_RI | {5'd0, reg_a};
                enc.bytes[4:1] = unsigned_value;
                enc.len        = 3'd5;
            end
            CMD_STORE_BDI:
            begin
                enc.bytes[0]   = OP_MOV_MI;
                enc.bytes[1]   = mrm(2'd1, 3'd0, reg_b);
                enc.bytes[2]   = sv8;
                enc.bytes[6:3] = unsigned_value;
                enc.len        = 3'd7;
            end
            CMD_INC, CMD_DEC:
            begin
                enc.bytes[0] = ((command == CMD_INC) ? 8'h40 : 8'h48) | {5'd0, reg_a};
                enc.len      = 3'd1;
            end
            CMD_CMP_RI:
            begin
                if (reg_a == 3'd0)
                begin
                    enc.bytes[0]   = 8'h3D;
                    enc.bytes[4:1] = signed_value;
                    enc.len        = 3'd5;
                end
                else if (fits_s8)
                begin
                    enc.bytes[0] = OP_GRP1_S8;
                    enc.bytes[1] = mrm(2'd3, 3'd7, reg_a);
                    enc.bytes[2] = sv8;
                    enc.len      = 3'd3;
                end
                else
                begin
                    enc.bytes[0]   = OP_GRP1_I32;
                    enc.bytes[1]   = mrm(2'd3, 3'd7, reg_a);
                    enc.bytes[5:2] = signed_value;
                    enc.len        = 3'd6;
                end
            end
            CMD_CALL_REL:
            begin
                enc.bytes[0]   = 8'hE8;
                enc.bytes[4:1] = signed_value;
                enc.len        = 3'd5;
            end
            CMD_JMP:
            begin
                if (fits_s8)
                begin
                    enc.bytes[0] = 8'hEB;
                    enc.bytes[1] = sv8;
                    enc.len      = 3'd2;
                end
                else
                begin
                    enc.bytes[0]   = OP_JMP_REL32;
                    enc.bytes[4:1] = signed_value;
                    enc.len        = 3'd5;
                end
            end
            CMD_MOVZX:
            begin
                enc.bytes[0] = OP_TWO_BYTE;
                enc.bytes[1] = 8'hB6;
                enc.bytes[2] = mrm(2'd3, reg_b, reg_a);
                enc.len      = 3'd3;
            end
            CMD_RET:
            begin
                enc.bytes[0] = 8'hC3;
                enc.len      = 3'd1;
            end
            CMD_RET_IMM:
            begin
                enc.bytes[0]   = 8'hC2;
                enc.bytes[2:1] = unsigned_value[15:0];
                enc.len        = 3'd3;
            end
            CMD_LEAVE:
            begin
                enc.bytes[0] = 8'hC9;
                enc.len      = 3'd1;
            end
            default:
            begin
                // unknown command: no bytes
                enc.len = 3'd0;
            end
        endcase
    end

endmodule

[rtl/xibe_serializer.sv]
// Byte serializer: holds one encoded instruction and shifts it out a beat at a time.
// Depends on xibe_pkg and xibe_out_if.
module xibe_serializer
    import xibe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  enc_t        enc,
    output logic        free,
    xibe_out_if.source  code
);

    logic [MaxBytes-1:0][7:0] buf_reg;
    logic [MaxBytes-1:0][7:0] buf_next;
    logic [2:0]               rem_reg;
    logic [2:0]               rem_next;
    logic                     beat;

    assign beat = code.valid && code.ready;
    // free for a new instruction when empty, or once the final byte leaves this cycle
    assign free = (rem_reg == 3'd0) || (beat && rem_reg == 3'd1);

    assign code.valid     = (rem_reg != 3'd0);
    assign code.code_byte = buf_reg[0];
    assign code.last      = (rem_reg == 3'd1);

    always_comb
    begin
        buf_next = buf_reg;
        rem_next = rem_reg;
        if (load)
        begin
            buf_next = enc.bytes;
            rem_next = enc.len;
        end
        else if (beat)
        begin
            // advance to the next byte
            buf_next = buf_reg >> 8;
            rem_next = rem_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 3'd0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

[rtl/x86_instruction_byte_encoder.sv]
// Top level of the x86 instruction byte encoder: input register, encoder, serializer.
// Depends on xibe_pkg, xibe_in_if, xibe_out_if, xibe_encoder and xibe_serializer.

// Takes one instruction request per beat on instr and emits its 32-bit x86 machine
// code on code, one byte per beat in emission order, with last set on the final
// byte; an instruction is 1 to 7 bytes and unknown commands (56 to 63) emit nothing.
// A request is held in an input register, encoded by combinational logic and loaded
// into a 7-byte shift register that drives the output. An instruction holds the output
// until all of its bytes have been taken; a zero-byte request is loaded but emits
// nothing. The next request is accepted while the current one is still shifting
// out, and the load follows the final byte with no gap. A request passes through
// the input register and then the shift register before its first byte appears.
module x86_instruction_byte_encoder
    import xibe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    xibe_in_if.sink    instr,
    xibe_out_if.source code
);

    logic        valid_reg;
    logic        valid_next;
    logic [5:0]  command_reg;
    logic [2:0]  reg_a_reg;
    logic [2:0]  reg_b_reg;
    logic [31:0] signed_value_reg;
    logic [31:0] unsigned_value_reg;
    logic        ser_free;
    logic        move;
    logic        take;
    enc_t        enc;

    assign move        = valid_reg && ser_free;
    assign instr.ready = !valid_reg || ser_free;
    assign take        = instr.valid && instr.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (move)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            command_reg        <= instr.command;
            reg_a_reg          <= instr.reg_a;
            reg_b_reg          <= instr.reg_b;
            signed_value_reg   <= instr.signed_value;
            unsigned_value_reg <= instr.unsigned_value;
        end
    end

    xibe_encoder u_encoder (
        .command        (command_reg),
        .reg_a          (reg_a_reg),
        .reg_b          (reg_b_reg),
        .signed_value   (signed_value_reg),
        .unsigned_value (unsigned_value_reg),
        .enc            (enc)
    );

    xibe_serializer u_serializer (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (move),
        .enc   (enc),
        .free  (ser_free),
        .code  (code)
    );

endmodule

[verif/xibe_byte_checker.sv]
// Byte checker for the x86 instruction byte encoder: watches the request and code channels,
// encodes each accepted request itself and compares every code beat in order.
// Depends on xibe_pkg, xibe_in_if and xibe_out_if.
module xibe_byte_checker
    import xibe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    xibe_in_if   instr,
    xibe_out_if  code,
    output int   mismatches,
    output int   bytes_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_EAX = 3'd0;
    localparam logic [2:0] REG_EBP = 3'd5;
    localparam logic [2:0] CMP_EXT = 3'd7;

    // Indexed by ALU operation: add, sub, or, and, xor.
    localparam logic [4:0][7:0] ALU_RR_OP  = {8'h31, 8'h21, 8'h09, 8'h29, 8'h01};
    localparam logic [4:0][7:0] ALU_AL8_OP = {8'h34, 8'h24, 8'h0C, 8'h2C, 8'h04};
    localparam logic [4:0][7:0] ALU_EAX_OP = {8'h35, 8'h25, 8'h0D, 8'h2D, 8'h05};
    localparam logic [4:0][2:0] ALU_EXT    = {3'd6, 3'd4, 3'd1, 3'd5, 3'd0};
    // Short jcc opcodes: e, ne, l, le, g, ge, a, ae, b, be.
    localparam logic [9:0][7:0] COND_OP    = {8'h76, 8'h72, 8'h73, 8'h77, 8'h7D,
                                              8'h7F, 8'h7E, 8'h7C, 8'h75, 8'h74};

    typedef struct packed {
        byte_t code_byte;
        logic  last;
    } code_beat_t;

    code_beat_t expected_beats[$];
    int         error_count;

    assign mismatches = error_count;

    function automatic void push_le(ref byte_t q[$], input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            q.push_back(v[8*i +: 8]);
    endfunction

    function automatic void encode_request(input logic [5:0] cmd, input logic [2:0] ra,
                                           input logic [2:0] rb, input logic [31:0] sv,
                                           input logic [31:0] uv);
        byte_t      enc[$];
        code_beat_t beat;
        logic [5:0] sub_idx;
        logic [2:0] alu_op;
        logic [2:0] base;
        logic [1:0] md;
        byte_t      cc;
        logic       short_disp;
        logic       byte_imm;
        logic       store;
        logic       fits;

        short_disp = ($signed(sv) >= -128) && ($signed(sv) <= 127);
        byte_imm   = (sv[31:8] == 24'd0);
        if (cmd >= CMD_ALU_FIRST && cmd <= CMD_ALU_LAST) begin
            sub_idx = cmd - CMD_ALU_FIRST;
            alu_op  = sub_idx[3:1];
            if (!sub_idx[0]) begin
                enc.push_back(ALU_RR_OP[alu_op]);
                enc.push_back({2'b11, rb, ra});
            end
            else if (ra == REG_EAX) begin
                enc.push_back(byte_imm ? ALU_AL8_OP[alu_op] : ALU_EAX_OP[alu_op]);
                push_le(enc, sv, byte_imm ? 1 : 4);
            end
            else begin
                enc.push_back(byte_imm ? OP_GRP1_I8 : OP_GRP1_I32);
                enc.push_back({2'b11, ALU_EXT[alu_op], ra});
                push_le(enc, sv, byte_imm ? 1 : 4);
            end
        end
        else if (cmd >= CMD_JCC_FIRST && cmd <= CMD_JCC_LAST) begin
            sub_idx = cmd - CMD_JCC_FIRST;
            cc = COND_OP[sub_idx];
            if (short_disp) begin
                enc.push_back(cc);
                enc.push_back(sv[7:0]);
            end
            else begin
                enc.push_back(OP_TWO_BYTE);
                enc.push_back(cc + 8'h10);
                push_le(enc, sv, 4);
            end
        end
        else if (cmd >= CMD_SETCC_FIRST && cmd <= CMD_SETCC_LAST) begin
            sub_idx = cmd - CMD_SETCC_FIRST;
            enc.push_back(OP_TWO_BYTE);
            enc.push_back(COND_OP[sub_idx] + 8'h20);
            enc.push_back({2'b11, ra, ra});
        end
        else begin
            case (cmd)
                CMD_PUSH_R: enc.push_back(OP_PUSH_R | {5'd0, ra});
                CMD_PUSH_I8:
                begin
                    enc.push_back(8'h6A);
                    enc.push_back(uv[7:0]);
                end
                CMD_PUSH_I32:
                begin
                    enc.push_back(8'h68);
                    push_le(enc, uv, 4);
                end
                CMD_PUSH_M:
                begin
                    enc.push_back(OP_GRP5);
                    enc.push_back(8'h35);
                    push_le(enc, uv, 4);
                end
                CMD_POP_R: enc.push_back(OP_POP_R | {5'd0, ra});
                CMD_MOV_RR:
                begin
                    enc.push_back(OP_MOV_STORE);
                    enc.push_back({2'b11, rb, ra});
                end
                CMD_LOAD_BD, CMD_STORE_BD, CMD_LOAD_FR, CMD_STORE_FR:
                begin
                    store = (cmd == CMD_STORE_BD) || (cmd == CMD_STORE_FR);
                    // frame forms are ebp based and take the 0..255 short range
                    if (cmd == CMD_LOAD_FR || cmd == CMD_STORE_FR) begin
                        base = REG_EBP;
                        fits = byte_imm;
                    end
                    else begin
                        base = rb;
                        fits = short_disp;
                    end
                    md = fits ? 2'b01 : 2'b10;
                    enc.push_back(store ? OP_MOV_STORE : OP_MOV_LOAD);
                    enc.push_back({md, ra, base});
                    push_le(enc, sv, fits ? 1 : 4);
                end
                CMD_LOAD_ABS, CMD_STORE_ABS:
                begin
                    store = (cmd == CMD_STORE_ABS);
                    if (ra == REG_EAX) begin
                        enc.push_back(store ? 8'hA3 : 8'hA1);
                    end
                    else begin
                        enc.push_back(store ? OP_MOV_STORE : OP_MOV_LOAD);
                        enc.push_back({2'b00, ra, REG_EBP});
                    end
                    push_le(enc, uv, 4);
                end
                CMD_MOV_RI:
                begin
                    enc.push_back(OP_MOV_RI | {5'd0, ra});
                    push_le(enc, uv, 4);
                end
                CMD_STORE_BDI:
                begin
                    enc.push_back(OP_MOV_MI);
                    enc.push_back({2'b01, 3'd0, rb});
                    enc.push_back(sv[7:0]);
                    push_le(enc, uv, 4);
                end
                CMD_INC: enc.push_back(8'h40 | {5'd0, ra});
                CMD_DEC: enc.push_back(8'h48 | {5'd0, ra});
                CMD_TEST_RR:
                begin
                    enc.push_back(8'h85);
                    enc.push_back({2'b11, rb, ra});
                end
                CMD_CMP_RR:
                begin
                    enc.push_back(8'h39);
                    enc.push_back({2'b11, rb, ra});
                end
                CMD_CMP_RI:
                begin
                    // eax never takes the short form
                    if (ra == REG_EAX) begin
                        enc.push_back(8'h3D);
                        push_le(enc, sv, 4);
                    end
                    else begin
                        enc.push_back(short_disp ? OP_GRP1_S8 : OP_GRP1_I32);
                        enc.push_back({2'b11, CMP_EXT, ra});
                        push_le(enc, sv, short_disp ? 1 : 4);
                    end
                end
                CMD_CALL_M:
                begin
                    enc.push_back(OP_GRP5);
                    enc.push_back(8'h15);
                    push_le(enc, uv, 4);
                end
                CMD_CALL_REL:
                begin
                    enc.push_back(8'hE8);
                    push_le(enc, sv, 4);
                end
                CMD_JMP:
                begin
                    enc.push_back(short_disp ? 8'hEB : OP_JMP_REL32);
                    push_le(enc, sv, short_disp ? 1 : 4);
                end
                CMD_MOVZX:
                begin
                    enc.push_back(OP_TWO_BYTE);
                    enc.push_back(8'hB6);
                    enc.push_back({2'b11, rb, ra});
                end
                CMD_RET: enc.push_back(8'hC3);
                CMD_RET_IMM:
                begin
                    enc.push_back(8'hC2);
                    push_le(enc, uv, 2);
                end
                CMD_LEAVE: enc.push_back(8'hC9);
                default: ;
            endcase
        end

        foreach (enc[k]) begin
            beat.code_byte = enc[k];
            beat.last      = (k == enc.size() - 1);
            expected_beats.push_back(beat);
        end
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%0t: code beat error: %s", $time, msg);
    endtask

    always @(posedge clk) begin
        code_beat_t want;
        if (rst_n) begin
            if (instr.valid && instr.ready)
                encode_request(instr.command, instr.reg_a, instr.reg_b,
                               instr.signed_value, instr.unsigned_value);
            if (code.valid && code.ready) begin
                if (expected_beats.size() == 0) begin
                    report_error($sformatf("no byte expected, got %h last %b",
                                           code.code_byte, code.last));
                end
                else begin
                    want = expected_beats.pop_front();
                    if (want.code_byte !== code.code_byte || want.last !== code.last)
                        report_error($sformatf("expected %h last %b, got %h last %b",
                                               want.code_byte, want.last,
                                               code.code_byte, code.last));
                end
            end
        end
        bytes_pending <= expected_beats.size();
    end

endmodule

[verif/tb_x86_instruction_byte_encoder.sv]
// Testbench top for the x86 instruction byte encoder: clock, reset, request stimulus,
// random back-pressure on the code channel and the verdict.
// Depends on xibe_pkg, xibe_in_if, xibe_out_if, xibe_byte_checker and the encoder RTL.
module tb_x86_instruction_byte_encoder
    import xibe_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 32;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   bytes_pending;
    int   sender_idle_pct;
    int   receiver_stall_pct;
    bit   timed_out;

    xibe_in_if  instr();
    xibe_out_if code();

    x86_instruction_byte_encoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .instr (instr),
        .code  (code)
    );

    xibe_byte_checker byte_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .instr         (instr),
        .code          (code),
        .mismatches    (mismatches),
        .bytes_pending (bytes_pending)
    );

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
        code.ready <= ($urandom_range(99) >= receiver_stall_pct);

    task automatic send_request(input logic [5:0] cmd, input logic [2:0] ra,
                                input logic [2:0] rb, input logic [31:0] sv,
                                input logic [31:0] uv);
        while ($urandom_range(99) < sender_idle_pct) begin
            instr.valid <= 1'b0;
            @(posedge clk);
        end
        instr.valid          <= 1'b1;
        instr.command        <= cmd;
        instr.reg_a          <= ra;
        instr.reg_b          <= rb;
        instr.signed_value   <= sv;
        instr.unsigned_value <= uv;
        do
            @(posedge clk);
        while (!instr.ready);
    endtask

    // Drop valid and hold until every expected byte has come out.
    task automatic wait_for_drain();
        instr.valid <= 1'b0;
        do
            @(posedge clk);
        while (bytes_pending != 0);
    endtask

    // Bias values toward the short/long form boundaries.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return $urandom_range(255);
            1: return $urandom_range(255) - 128;
            2:
            begin
                case ($urandom_range(5))
                    0: return 32'hFFFF_FF7F;
                    1: return 32'd128;
                    2: return 32'd256;
                    3: return 32'h7FFF_FFFF;
                    4: return 32'h8000_0000;
                    default: return 32'hFFFF_FF80;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(input int count);
        int         sent;
        logic [5:0] cmd;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(15) == 0)
                cmd = 6'($urandom_range(63, 56));
            else
                cmd = 6'($urandom_range(55, 0));
            send_request(cmd, 3'($urandom), 3'($urandom), pick_value(), pick_value());
            // unknown commands produce no bytes, so they do not count
            if (cmd <= CMD_LEAVE)
                sent++;
        end
    endtask

    task automatic watch_progress();
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge clk);
            if ((instr.valid && instr.ready) || (code.valid && code.ready))
                idle = 0;
            else
                idle++;
        end
        timed_out = 1'b1;
    endtask

    initial begin
        rst_n                = 1'b0;
        timed_out            = 1'b0;
        sender_idle_pct      = 0;
        receiver_stall_pct   = 0;
        instr.valid          = 1'b0;
        instr.command        = '0;
        instr.reg_a          = '0;
        instr.reg_b          = '0;
        instr.signed_value   = '0;
        instr.unsigned_value = '0;
        code.ready           = 1'b0;

        fork
            begin
                repeat (2) @(posedge clk);
                rst_n <= 1'b1;
                @(posedge clk);

                // directed: a selection of encoding paths and range edges
                send_request(CMD_PUSH_R,     3'd7, 3'd0, 0,            0);
                send_request(CMD_PUSH_I8,    3'd0, 3'd0, 0,            32'hFFFF_FFFF);
                send_request(CMD_PUSH_I32,   3'd0, 3'd0, 0,            32'hFFFF_FFFF);
                send_request(CMD_PUSH_M,     3'd0, 3'd0, 0,            32'h0000_0000);
                send_request(CMD_POP_R,      3'd0, 3'd7, 0,            0);
                send_request(CMD_MOV_RR,     3'd7, 3'd0, 0,            0);
                send_request(CMD_LOAD_BD,    3'd1, 3'd5, 127,          0);
                send_request(CMD_STORE_BD,   3'd6, 3'd4, -129,         0);
                send_request(CMD_LOAD_FR,    3'd2, 3'd0, 255,          0);
                send_request(CMD_STORE_FR,   3'd3, 3'd0, -1,           0);
                send_request(CMD_LOAD_ABS,   3'd0, 3'd0, 0,            32'h1234_5678);
                send_request(CMD_STORE_ABS,  3'd7, 3'd0, 0,            32'h8765_4321);
                send_request(CMD_MOV_RI,     3'd7, 3'd0, 0,            32'h8000_0001);
                send_request(CMD_STORE_BDI,  3'd0, 3'd7, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
                send_request(CMD_ALU_FIRST + 6'd1, 3'd0, 3'd0, 255,    0);
                send_request(CMD_ALU_FIRST + 6'd7, 3'd0, 3'd0, 256,    0);
                send_request(CMD_ALU_FIRST + 6'd9, 3'd3, 3'd0, 0,      0);
                send_request(CMD_ALU_FIRST + 6'd3, 3'd5, 3'd0, -1,     0);
                send_request(CMD_ALU_FIRST + 6'd6, 3'd2, 3'd6, 0,      0);
                send_request(CMD_ALU_FIRST + 6'd8, 3'd4, 3'd1, 0,      0);
                send_request(CMD_CMP_RI,     3'd0, 3'd0, -128,         0);
                send_request(CMD_CMP_RI,     3'd1, 3'd0, -128,         0);
                send_request(CMD_CMP_RI,     3'd2, 3'd0, 128,          0);
                send_request(CMD_JMP,        3'd0, 3'd0, 32'h8000_0000, 0);
                send_request(CMD_JCC_LAST,   3'd0, 3'd0, 127,          0);
                send_request(CMD_SETCC_LAST, 3'd7, 3'd0, 0,            0);
                send_request(CMD_RET_IMM,    3'd0, 3'd0, 0,            32'hFFFF_ABCD);
                send_request(6'd63,          3'd7, 3'd7, -1,           32'hFFFF_FFFF);

                wait_for_drain();

                send_random(PHASE_ITEMS);
                sender_idle_pct    = 82;
                send_random(PHASE_ITEMS);
                sender_idle_pct    = 0;
                receiver_stall_pct = 82;
                send_random(PHASE_ITEMS);
                sender_idle_pct    = 17;
                receiver_stall_pct = 17;
                send_random(PHASE_ITEMS);

                wait_for_drain();
                repeat (20) @(posedge clk);
            end
            watch_progress();
        join_any

        if (!timed_out && mismatches == 0)
            $display("x86_instruction_byte_encoder: match");
        else
            $display("x86_instruction_byte_encoder: mismatch");
        $finish;
    end

endmodule

[files.f]
rtl/xibe_pkg.sv
rtl/xibe_in_if.sv
rtl/xibe_out_if.sv
rtl/xibe_encoder.sv
rtl/xibe_serializer.sv
rtl/x86_instruction_byte_encoder.sv
verif/xibe_byte_checker.sv
verif/tb_x86_instruction_byte_encoder.sv
